>>> rtl/cobs_crc_frame_receiver_core_macros.svh
// ----------------------------------------------------------------------------
// COBS CRC frame receiver assertion macros
// Shared concurrent assertion forms for the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef COBS_CRC_FRAME_RECEIVER_CORE_MACROS_SVH
`define COBS_CRC_FRAME_RECEIVER_CORE_MACROS_SVH

// same-cycle implication
`define CCFR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCFR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ccfr_pkg.sv
// ----------------------------------------------------------------------------
// ccfr_pkg
// Types, reply strings, length table and CRC step for the frame receiver.
// ----------------------------------------------------------------------------
package ccfr_pkg;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_RSP1     = 4'd1,
    ST_RSP2     = 4'd2,
    ST_RSP3     = 4'd3,
    ST_RSP4     = 4'd4,
    ST_COBS     = 4'd5,
    ST_FRAMING  = 4'd6,
    ST_CRC      = 4'd7,
    ST_OVERFLOW = 4'd8
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_D_ADDR,
    S_D_CODE,
    S_D_READ,
    S_D_WRITE,
    S_D_GAP,
    S_T_START,
    S_T_ADDR,
    S_T_CMP,
    S_K_ADDR,
    S_K_CHK,
    S_C_ADDR,
    S_C_STEP,
    S_R_LO,
    S_R_HI,
    S_R_CMP,
    S_E_ADDR,
    S_E_OUT,
    S_EMIT
  } state_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] kind;
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       init;
    logic       step;
    logic [7:0] data;
  } crc_cmd_t;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA2EB;
  localparam logic [7:0]  COBS_MAX_CODE = 8'hFF;
  localparam logic [1:0]  RSP_LAST_SEL = 2'd3;

  localparam logic [18*8-1:0] RSP1_STR = "Command succeed.\r\n";
  localparam logic [17*8-1:0] RSP2_STR = "Command failed.\r\n";
  localparam logic [28*8-1:0] RSP3_STR = "This command is erroneous.\r\n";
  localparam logic [38*8-1:0] RSP4_STR = "This command is not implemented yet.\r\n";

  function automatic logic [5:0] rsp_len(input logic [1:0] sel);
    logic [5:0] r;
    unique case (sel)
      2'd0: r = 6'd18;
      2'd1: r = 6'd17;
      2'd2: r = 6'd28;
      default: r = 6'd38;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rsp_char(input logic [1:0] sel, input logic [5:0] i);
    int p;
    logic [7:0] c;
    p = int'(rsp_len(sel)) - 1 - int'(i);
    if (p < 0) p = 0;
    unique case (sel)
      2'd0: c = RSP1_STR[p*8 +: 8];
      2'd1: c = RSP2_STR[p*8 +: 8];
      2'd2: c = RSP3_STR[p*8 +: 8];
      default: c = RSP4_STR[p*8 +: 8];
    endcase
    return c;
  endfunction

  function automatic status_t rsp_status(input logic [1:0] sel);
    status_t s;
    unique case (sel)
      2'd0: s = ST_RSP1;
      2'd1: s = ST_RSP2;
      2'd2: s = ST_RSP3;
      default: s = ST_RSP4;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] kind_len(input logic [2:0] kind);
    logic [7:0] r;
    unique case (kind)
      3'd0: r = 8'd61;
      3'd1: r = 8'd25;
      3'd2: r = 8'd29;
      3'd3: r = 8'd49;
      3'd4: r = 8'd64;
      3'd5: r = 8'd58;
      3'd6: r = 8'd58;
      default: r = 8'd40;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/ccfr_ram.sv
// ----------------------------------------------------------------------------
// ccfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ccfr_crc.sv
// ----------------------------------------------------------------------------
// ccfr_crc
// CRC-16 accumulator, one byte per step, polynomial 0xA2EB.
// ----------------------------------------------------------------------------
module ccfr_crc (
  input  logic               clk,
  input  ccfr_pkg::crc_cmd_t cmd,
  output logic [15:0]        crc
);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      crc <= ccfr_pkg::CRC_INIT;
    end else if (cmd.step) begin
      crc <= ccfr_pkg::crc_byte(crc, cmd.data);
    end
  end

endmodule

>>> rtl/ccfr_ctrl.sv
// ----------------------------------------------------------------------------
// ccfr_ctrl
// Sequencer: buffers line bytes, decodes COBS, checks replies, length and CRC.
// ----------------------------------------------------------------------------
`include "cobs_crc_frame_receiver_core_macros.svh"

module ccfr_ctrl #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [7:0]                      in_byte,
  input  logic                            out_free,
  output logic                            push,
  output ccfr_pkg::res_t                  res,
  output logic                            enc_we,
  output logic [$clog2(BUFFER_BYTES)-1:0] enc_waddr,
  output logic [7:0]                      enc_wdata,
  output logic [$clog2(BUFFER_BYTES)-1:0] enc_raddr,
  input  logic [7:0]                      enc_rdata,
  output logic                            dec_we,
  output logic [$clog2(BUFFER_BYTES)-1:0] dec_waddr,
  output logic [7:0]                      dec_wdata,
  output logic [$clog2(BUFFER_BYTES)-1:0] dec_raddr,
  input  logic [7:0]                      dec_rdata,
  output ccfr_pkg::crc_cmd_t              crc_cmd,
  input  logic [15:0]                     crc
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int LW = $clog2(BUFFER_BYTES + 1);
  localparam int CW = LW + 8;

  ccfr_pkg::state_t  state, state_next;
  logic              sync;
  logic [LW-1:0]     enc_len;
  logic [LW-1:0]     flen;
  logic [LW-1:0]     in_ptr;
  logic [LW-1:0]     out_ptr;
  logic [LW-1:0]     idx;
  logic [7:0]        remain;
  logic [7:0]        code;
  logic [1:0]        sel;
  logic [7:0]        rx_lo;
  ccfr_pkg::status_t st;
  logic [2:0]        st_kind;

  logic          accept;
  logic          buf_full;
  logic [LW-1:0] in_new;
  logic [7:0]    code_n;
  logic          cobs_err;
  logic [LW-1:0] rlen;
  logic [LW-1:0] tail_addr;
  logic          char_hit;
  logic          len_ok;
  logic          crc_ok;
  logic          crc_done;
  logic          emit_last;

  assign in_ready  = (state == ccfr_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign buf_full  = (enc_len == LW'(BUFFER_BYTES));
  assign in_new    = in_ptr + LW'(1);
  assign code_n    = enc_rdata - 8'd1;
  assign cobs_err  = (enc_rdata == 8'd0) || (CW'(code_n) > CW'(flen - in_new));
  assign rlen      = LW'(ccfr_pkg::rsp_len(sel));
  assign tail_addr = out_ptr - rlen + idx;
  assign char_hit  = (dec_rdata == ccfr_pkg::rsp_char(sel, idx[5:0]));
  assign len_ok    = (out_ptr == LW'(ccfr_pkg::kind_len(dec_rdata[2:0])));
  assign crc_ok    = (crc == {dec_rdata, rx_lo});
  assign crc_done  = (idx == out_ptr - LW'(3));
  assign emit_last = (idx == out_ptr - LW'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ccfr_pkg::S_IDLE: begin
        if (accept && !in_action) begin
          if (in_byte == 8'd0) begin
            if (sync && enc_len != '0) state_next = ccfr_pkg::S_D_ADDR;
          end else if (sync && buf_full) begin
            state_next = ccfr_pkg::S_EMIT;
          end
        end
      end
      ccfr_pkg::S_D_ADDR: state_next = ccfr_pkg::S_D_CODE;
      ccfr_pkg::S_D_CODE: begin
        if (cobs_err) state_next = ccfr_pkg::S_EMIT;
        else if (code_n == 8'd0) state_next = ccfr_pkg::S_D_GAP;
        else state_next = ccfr_pkg::S_D_READ;
      end
      ccfr_pkg::S_D_READ: state_next = ccfr_pkg::S_D_WRITE;
      ccfr_pkg::S_D_WRITE: begin
        if (remain == 8'd1) state_next = ccfr_pkg::S_D_GAP;
        else state_next = ccfr_pkg::S_D_READ;
      end
      ccfr_pkg::S_D_GAP: begin
        if (in_ptr >= flen) state_next = ccfr_pkg::S_T_START;
        else state_next = ccfr_pkg::S_D_ADDR;
      end
      ccfr_pkg::S_T_START: begin
        if (out_ptr >= rlen) state_next = ccfr_pkg::S_T_ADDR;
        else if (sel == ccfr_pkg::RSP_LAST_SEL) state_next = ccfr_pkg::S_K_ADDR;
      end
      ccfr_pkg::S_T_ADDR: state_next = ccfr_pkg::S_T_CMP;
      ccfr_pkg::S_T_CMP: begin
        if (!char_hit) begin
          if (sel == ccfr_pkg::RSP_LAST_SEL) state_next = ccfr_pkg::S_K_ADDR;
          else state_next = ccfr_pkg::S_T_START;
        end else if (idx == rlen - LW'(1)) begin
          state_next = ccfr_pkg::S_EMIT;
        end else begin
          state_next = ccfr_pkg::S_T_ADDR;
        end
      end
      ccfr_pkg::S_K_ADDR: begin
        if (out_ptr == '0) state_next = ccfr_pkg::S_EMIT;
        else state_next = ccfr_pkg::S_K_CHK;
      end
      ccfr_pkg::S_K_CHK: begin
        if (len_ok) state_next = ccfr_pkg::S_C_ADDR;
        else state_next = ccfr_pkg::S_EMIT;
      end
      ccfr_pkg::S_C_ADDR: state_next = ccfr_pkg::S_C_STEP;
      ccfr_pkg::S_C_STEP: begin
        if (crc_done) state_next = ccfr_pkg::S_R_LO;
        else state_next = ccfr_pkg::S_C_ADDR;
      end
      ccfr_pkg::S_R_LO: state_next = ccfr_pkg::S_R_HI;
      ccfr_pkg::S_R_HI: state_next = ccfr_pkg::S_R_CMP;
      ccfr_pkg::S_R_CMP: begin
        if (crc_ok) state_next = ccfr_pkg::S_E_ADDR;
        else state_next = ccfr_pkg::S_EMIT;
      end
      ccfr_pkg::S_E_ADDR: state_next = ccfr_pkg::S_E_OUT;
      ccfr_pkg::S_E_OUT: begin
        if (out_free) begin
          if (emit_last) state_next = ccfr_pkg::S_IDLE;
          else state_next = ccfr_pkg::S_E_ADDR;
        end
      end
      ccfr_pkg::S_EMIT: begin
        if (out_free) state_next = ccfr_pkg::S_IDLE;
      end
      default: state_next = ccfr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    enc_we    = accept && !in_action && (in_byte != 8'd0) && sync && !buf_full;
    enc_waddr = enc_len[AW-1:0];
    enc_wdata = in_byte;
    enc_raddr = in_ptr[AW-1:0];
    dec_we    = 1'b0;
    dec_waddr = out_ptr[AW-1:0];
    dec_wdata = 8'd0;
    dec_raddr = idx[AW-1:0];
    crc_cmd   = '{init: 1'b0, step: 1'b0, data: dec_rdata};
    push      = 1'b0;
    res       = '{status: st, kind: st_kind, data: 8'd0, byte_valid: 1'b0, last: 1'b1};
    unique case (state)
      ccfr_pkg::S_D_WRITE: begin
        dec_we    = 1'b1;
        dec_wdata = enc_rdata;
      end
      ccfr_pkg::S_D_GAP: begin
        dec_we = (in_ptr < flen) && (code != ccfr_pkg::COBS_MAX_CODE);
      end
      ccfr_pkg::S_T_ADDR: dec_raddr = tail_addr[AW-1:0];
      ccfr_pkg::S_K_ADDR: dec_raddr = '0;
      ccfr_pkg::S_K_CHK:  crc_cmd.init = len_ok;
      ccfr_pkg::S_C_STEP: crc_cmd.step = 1'b1;
      ccfr_pkg::S_R_LO:   dec_raddr = AW'(out_ptr - LW'(2));
      ccfr_pkg::S_R_HI:   dec_raddr = AW'(out_ptr - LW'(1));
      ccfr_pkg::S_E_OUT: begin
        push = out_free;
        res  = '{status: ccfr_pkg::ST_OK, kind: st_kind, data: dec_rdata,
                 byte_valid: 1'b1, last: emit_last};
      end
      ccfr_pkg::S_EMIT: push = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ccfr_pkg::S_IDLE;
      sync    <= 1'b0;
      enc_len <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (in_action) begin
          enc_len <= '0;
          sync    <= 1'b0;
        end else if (in_byte == 8'd0) begin
          enc_len <= '0;
          sync    <= 1'b1;
        end else if (sync && buf_full) begin
          enc_len <= '0;
          sync    <= 1'b0;
        end else if (sync) begin
          enc_len <= enc_len + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ccfr_pkg::S_IDLE: begin
        flen    <= enc_len;
        in_ptr  <= '0;
        out_ptr <= '0;
        sel     <= '0;
        st      <= ccfr_pkg::ST_OVERFLOW;
        st_kind <= '0;
      end
      ccfr_pkg::S_D_CODE: begin
        code   <= enc_rdata;
        remain <= code_n;
        in_ptr <= in_new;
        st     <= ccfr_pkg::ST_COBS;
      end
      ccfr_pkg::S_D_WRITE: begin
        in_ptr  <= in_new;
        out_ptr <= out_ptr + LW'(1);
        remain  <= remain - 8'd1;
      end
      ccfr_pkg::S_D_GAP: begin
        idx <= '0;
        if (dec_we) out_ptr <= out_ptr + LW'(1);
      end
      ccfr_pkg::S_T_START: begin
        idx <= '0;
        if (out_ptr < rlen && sel != ccfr_pkg::RSP_LAST_SEL) sel <= sel + 2'd1;
      end
      ccfr_pkg::S_T_CMP: begin
        st  <= ccfr_pkg::rsp_status(sel);
        idx <= idx + LW'(1);
        if (!char_hit && sel != ccfr_pkg::RSP_LAST_SEL) sel <= sel + 2'd1;
      end
      ccfr_pkg::S_K_ADDR: st <= ccfr_pkg::ST_FRAMING;
      ccfr_pkg::S_K_CHK: begin
        st_kind <= dec_rdata[2:0];
        idx     <= '0;
      end
      ccfr_pkg::S_C_STEP: idx <= idx + LW'(1);
      ccfr_pkg::S_R_HI: rx_lo <= dec_rdata;
      ccfr_pkg::S_R_CMP: begin
        st  <= ccfr_pkg::ST_CRC;
        idx <= '0;
      end
      ccfr_pkg::S_E_OUT: begin
        if (out_free) idx <= idx + LW'(1);
      end
      default: ;
    endcase
  end

  `CCFR_ASSERT_IMP(a_push_free, clk, rst, push, out_free, "result pushed into busy output")
  `CCFR_ASSERT_IMP(a_valid_ok, clk, rst, push && res.byte_valid,
                   res.status == ccfr_pkg::ST_OK, "frame byte carries error status")
  `CCFR_ASSERT_NXT(a_last_idle, clk, rst, push && res.last,
                   state == ccfr_pkg::S_IDLE, "sequencer busy after last result")

endmodule

>>> rtl/cobs_crc_frame_receiver_core.sv
// Flow: line bytes are taken while idle; a delimiter that closes a frame runs
//   COBS decode, reply compare, length check, CRC check and frame output in turn,
//   all on one RAM read port per buffer.
// Throughput: one line byte per cycle between frames; busy during frame-end work and overflow reports.
// Reset (rst, synchronous): unsynced, buffer empty, no result pending.
// ----------------------------------------------------------------------------
// cobs_crc_frame_receiver_core
// COBS deframer with reply detection, length check and CRC-16 check.
// ----------------------------------------------------------------------------
module cobs_crc_frame_receiver_core #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] line_byte
  input  logic [0:0] s_axis_tuser,  // [0] action
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_byte
  output logic [7:0] m_axis_tuser,  // [3:0] status, [6:4] frame_kind, [7] byte_valid
  output logic       m_axis_tlast
);

  localparam int AW = $clog2(BUFFER_BYTES);

  logic               out_free;
  logic               push;
  ccfr_pkg::res_t     res_c;
  ccfr_pkg::res_t     res;
  logic               enc_we;
  logic [AW-1:0]      enc_waddr;
  logic [7:0]         enc_wdata;
  logic [AW-1:0]      enc_raddr;
  logic [7:0]         enc_rdata;
  logic               dec_we;
  logic [AW-1:0]      dec_waddr;
  logic [7:0]         dec_wdata;
  logic [AW-1:0]      dec_raddr;
  logic [7:0]         dec_rdata;
  ccfr_pkg::crc_cmd_t crc_cmd;
  logic [15:0]        crc;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  ccfr_ctrl #(.BUFFER_BYTES(BUFFER_BYTES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser[0]),
    .in_byte   (s_axis_tdata),
    .out_free  (out_free),
    .push      (push),
    .res       (res_c),
    .enc_we    (enc_we),
    .enc_waddr (enc_waddr),
    .enc_wdata (enc_wdata),
    .enc_raddr (enc_raddr),
    .enc_rdata (enc_rdata),
    .dec_we    (dec_we),
    .dec_waddr (dec_waddr),
    .dec_wdata (dec_wdata),
    .dec_raddr (dec_raddr),
    .dec_rdata (dec_rdata),
    .crc_cmd   (crc_cmd),
    .crc       (crc)
  );

  ccfr_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_enc_ram (
    .clk   (clk),
    .we    (enc_we),
    .waddr (enc_waddr),
    .wdata (enc_wdata),
    .raddr (enc_raddr),
    .rdata (enc_rdata)
  );

  ccfr_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_dec_ram (
    .clk   (clk),
    .we    (dec_we),
    .waddr (dec_waddr),
    .wdata (dec_wdata),
    .raddr (dec_raddr),
    .rdata (dec_rdata)
  );

  ccfr_crc u_crc (
    .clk (clk),
    .cmd (crc_cmd),
    .crc (crc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res <= res_c;
    end
  end

  assign m_axis_tdata = res.data;
  assign m_axis_tuser = {res.byte_valid, res.kind, res.status};
  assign m_axis_tlast = res.last;

endmodule

>>> sim/cobs_crc_frame_receiver_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_crc_frame_receiver_core_checker
// Watches both streams of the frame receiver, predicts the decoded frames and
// statuses for every accepted line byte, and compares them in order.
// ----------------------------------------------------------------------------
module cobs_crc_frame_receiver_core_checker #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic [0:0] s_axis_tuser,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,
  input  logic [7:0] m_axis_tuser,
  input  logic       m_axis_tlast,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    ccfr_pkg::status_t status;
    logic [2:0]        kind;
    logic [7:0]        data;
    logic              byte_valid;
    logic              last;
  } rx_result_t;

  rx_result_t expected_results[$];
  logic       synced;
  int         enc_len;
  logic [7:0] enc_buf[BUFFER_BYTES];
  logic [7:0] dec_buf[BUFFER_BYTES];
  int         dec_len;

  function automatic rx_result_t status_result(ccfr_pkg::status_t s, logic [2:0] k);
    rx_result_t r;
    r.status = s;
    r.kind = k;
    r.data = 8'h00;
    r.byte_valid = 1'b0;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic tail_matches(string s);
    if (dec_len < s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++)
      if (dec_buf[dec_len - s.len() + i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] frame_length(logic [2:0] k);
    case (k)
      3'd0: return 8'd61;
      3'd1: return 8'd25;
      3'd2: return 8'd29;
      3'd3: return 8'd49;
      3'd4: return 8'd64;
      3'd5: return 8'd58;
      3'd6: return 8'd58;
      default: return 8'd40;
    endcase
  endfunction

  task automatic close_frame();
    int         rd;
    int         wr;
    int         run;
    logic [7:0] code;
    logic [2:0] k;
    logic [15:0] crc;
    logic [15:0] trailer;
    rx_result_t r;
    rd = 0;
    wr = 0;
    while (rd < enc_len) begin
      code = enc_buf[rd];
      rd++;
      run = int'(code) - 1;
      if (run > enc_len - rd) begin
        expected_results.push_back(status_result(ccfr_pkg::ST_COBS, 3'd0));
        return;
      end
      for (int j = 0; j < run; j++) begin
        if (wr < BUFFER_BYTES) begin
          dec_buf[wr] = enc_buf[rd];
          wr++;
        end
        rd++;
      end
      if (rd >= enc_len) break;
      if (code != 8'hFF && wr < BUFFER_BYTES) begin
        dec_buf[wr] = 8'h00;
        wr++;
      end
    end
    dec_len = wr;
    if (tail_matches("Command succeed.\r\n")) begin
      expected_results.push_back(status_result(ccfr_pkg::ST_RSP1, 3'd0));
      return;
    end
    if (tail_matches("Command failed.\r\n")) begin
      expected_results.push_back(status_result(ccfr_pkg::ST_RSP2, 3'd0));
      return;
    end
    if (tail_matches("This command is erroneous.\r\n")) begin
      expected_results.push_back(status_result(ccfr_pkg::ST_RSP3, 3'd0));
      return;
    end
    if (tail_matches("This command is not implemented yet.\r\n")) begin
      expected_results.push_back(status_result(ccfr_pkg::ST_RSP4, 3'd0));
      return;
    end
    if (dec_len == 0) begin
      expected_results.push_back(status_result(ccfr_pkg::ST_FRAMING, 3'd0));
      return;
    end
    k = dec_buf[0][2:0];
    if (dec_len != int'(frame_length(k))) begin
      expected_results.push_back(status_result(ccfr_pkg::ST_FRAMING, k));
      return;
    end
    crc = 16'hFFFF;
    for (int i = 0; i < dec_len - 2; i++) begin
      crc = crc ^ {dec_buf[i], 8'h00};
      for (int b = 0; b < 8; b++)
        crc = crc[15] ? ({crc[14:0], 1'b0} ^ 16'hA2EB) : {crc[14:0], 1'b0};
    end
    trailer = {dec_buf[dec_len - 1], dec_buf[dec_len - 2]};
    if (crc != trailer) begin
      expected_results.push_back(status_result(ccfr_pkg::ST_CRC, k));
      return;
    end
    for (int i = 0; i < dec_len; i++) begin
      r.status = ccfr_pkg::ST_OK;
      r.kind = k;
      r.data = dec_buf[i];
      r.byte_valid = 1'b1;
      r.last = (i == dec_len - 1);
      expected_results.push_back(r);
    end
  endtask

  task automatic take_line_byte(logic resync, logic [7:0] b);
    if (resync) begin
      enc_len = 0;
      synced = 1'b0;
    end else if (b == 8'h00) begin
      if (synced && enc_len > 0) close_frame();
      enc_len = 0;
      synced = 1'b1;
    end else if (synced) begin
      if (enc_len >= BUFFER_BYTES) begin
        enc_len = 0;
        synced = 1'b0;
        expected_results.push_back(status_result(ccfr_pkg::ST_OVERFLOW, 3'd0));
      end else begin
        enc_buf[enc_len] = b;
        enc_len++;
      end
    end
  endtask

  always @(posedge clk) begin
    rx_result_t got;
    rx_result_t want;
    if (rst) begin
      synced = 1'b0;
      enc_len = 0;
      dec_len = 0;
      errors = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = ccfr_pkg::status_t'(m_axis_tuser[3:0]);
        got.kind = m_axis_tuser[6:4];
        got.byte_valid = m_axis_tuser[7];
        got.data = m_axis_tdata;
        got.last = m_axis_tlast;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer: %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected st=%0d kind=%0d data=%h bv=%b last=%b,",
                        " got st=%0d kind=%0d data=%h bv=%b last=%b"},
                       want.status, want.kind, want.data, want.byte_valid, want.last,
                       got.status, got.kind, got.data, got.byte_valid, got.last);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) take_line_byte(s_axis_tuser[0], s_axis_tdata);
    end
    pending = expected_results.size();
  end

endmodule

>>> sim/cobs_crc_frame_receiver_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_crc_frame_receiver_core_tb
// Feeds COBS-encoded frames, replies, malformed and overflowing runs to the
// receiver under varied idle and stall patterns; a checker compares results.
// ----------------------------------------------------------------------------
module cobs_crc_frame_receiver_core_tb;

  localparam int BUFFER_BYTES = 128;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [7:0] m_axis_tuser;
  logic       m_axis_tlast;
  int         errors;
  int         pending;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_off;
  logic       hold_req;
  logic       hold_done;
  int         quiet_cycles;
  logic [7:0] plain[$];
  logic [7:0] line[$];

  cobs_crc_frame_receiver_core #(.BUFFER_BYTES(BUFFER_BYTES)) dut (.*);

  cobs_crc_frame_receiver_core_checker #(.BUFFER_BYTES(BUFFER_BYTES)) chk (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .errors, .pending
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // receiver stall; a hold-off request blocks it for a counted stretch
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_off <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_off <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_off > 0) begin
      m_axis_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[cobs_crc_frame_receiver_core] ERROR");
      $finish;
    end
  end

  task automatic send(logic resync, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= resync;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] frame_crc(int n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c = c ^ {plain[i], 8'h00};
      for (int b = 0; b < 8; b++)
        c = c[15] ? ({c[14:0], 1'b0} ^ 16'hA2EB) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // encode plain[] into line[] and send it with a closing delimiter
  task automatic send_encoded();
    int code_pos;
    line.delete();
    code_pos = 0;
    line.push_back(8'h01);
    foreach (plain[i]) begin
      if (plain[i] == 8'h00) begin
        code_pos = line.size();
        line.push_back(8'h01);
      end else begin
        line.push_back(plain[i]);
        line[code_pos]++;
        if (line[code_pos] == 8'hFF && i != plain.size() - 1) begin
          code_pos = line.size();
          line.push_back(8'h01);
        end
      end
    end
    foreach (line[i]) send(1'b0, line[i]);
    send(1'b0, 8'h00);
  endtask

  // frame of given kind; bad_crc flips a trailer bit, len_adj changes its length
  task automatic make_frame(logic [2:0] k, int zero_pct, logic bad_crc, int len_adj);
    int n;
    logic [15:0] c;
    n = (k == 0) ? 61 : (k == 1) ? 25 : (k == 2) ? 29 : (k == 3) ? 49 :
        (k == 4) ? 64 : (k == 7) ? 40 : 58;
    n = n + len_adj;
    plain.delete();
    for (int i = 0; i < n - 2; i++)
      plain.push_back(($urandom_range(99) < zero_pct) ? 8'h00 : 8'($urandom));
    plain[0][2:0] = k;
    c = frame_crc(n - 2) ^ (bad_crc ? 16'h0001 << $urandom_range(15) : 16'h0);
    plain.push_back(c[7:0]);
    plain.push_back(c[15:8]);
  endtask

  task automatic make_reply(string s);
    plain.delete();
    repeat ($urandom_range(3)) plain.push_back(8'($urandom));
    for (int i = 0; i < s.len(); i++) plain.push_back(s[i]);
  endtask

  task automatic random_item();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) begin
      make_frame(3'($urandom), $urandom_range(30), $urandom_range(9) == 0,
                 ($urandom_range(9) == 0) ? int'($urandom_range(2)) - 1 : 0);
      if (plain.size() > 0) send_encoded();
    end else if (sel < 70) begin
      case ($urandom_range(3))
        0: make_reply("Command succeed.\r\n");
        1: make_reply("Command failed.\r\n");
        2: make_reply("This command is erroneous.\r\n");
        default: make_reply("This command is not implemented yet.\r\n");
      endcase
      send_encoded();
    end else if (sel < 80) begin
      send(1'b0, 8'h40);
      repeat ($urandom_range(5)) send(1'b0, 8'($urandom_range(1, 255)));
      send(1'b0, 8'h00);
    end else if (sel < 85) begin
      send(1'b1, 8'($urandom));
      send(1'b0, 8'($urandom));
      send(1'b0, 8'h00);
    end else begin
      repeat ($urandom_range(1, 4)) send(1'b0, 8'($urandom));
    end
  endtask

  task automatic overflow_run();
    repeat (BUFFER_BYTES + 1) send(1'b0, 8'($urandom_range(1, 255)));
    send(1'b0, 8'h00);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tuser = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // unsynced bytes, resync, empty delimiters
    send(1'b0, 8'hFF);
    send(1'b1, 8'hFF);
    send(1'b0, 8'h00);
    send(1'b0, 8'h00);
    for (int k = 0; k < 8; k++) begin
      make_frame(3'(k), 10, 1'b0, 0);
      send_encoded();
    end
    make_frame(3'd7, 0, 1'b1, 0);
    send_encoded();
    make_frame(3'd4, 0, 1'b0, 1);
    send_encoded();
    make_reply("Command succeed.\r\n");
    send_encoded();
    make_reply("Command failed.\r\n");
    send_encoded();
    make_reply("This command is erroneous.\r\n");
    send_encoded();
    make_reply("This command is not implemented yet.\r\n");
    send_encoded();
    send(1'b0, 8'h05);
    send(1'b0, 8'h11);
    send(1'b0, 8'h00);
    send(1'b0, 8'h01);
    send(1'b0, 8'h00);
    overflow_run();
    send(1'b0, 8'h00);
    // long hold-off while frames keep coming
    hold_req = 1'b1;
    make_frame(3'd1, 5, 1'b0, 0);
    send_encoded();
    make_frame(3'd2, 5, 1'b0, 0);
    send_encoded();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 65 : (phase == 3) ? 27 : 0;
      recv_stall_pct = (phase == 2) ? 65 : (phase == 3) ? 27 : 0;
      repeat (28) random_item();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    overflow_run();
    s_axis_tvalid <= 1'b0;

    while (pending > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("[cobs_crc_frame_receiver_core] OK");
    else $display("[cobs_crc_frame_receiver_core] ERROR");
    $finish;
  end

endmodule
